[src/rfps_pkg.sv]
// ----------------------------------------------------------------------------
// RGB fade pattern sequencer package
// Shared types, command codes, size defaults and the built-in segment and
// pattern contents loaded at reset.
// ----------------------------------------------------------------------------
`default_nettype none

package rfps_pkg;

  localparam int SEGMENTS_DEF = 64;
  localparam int PATTERNS_DEF = 5;
  localparam logic [6:0] MAX_TOTAL = 7'd64;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_WR_SEG = 3'd3;
  localparam logic [2:0] CMD_WR_PAT = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] steps;
  } seg_t;

  // Work handed to one colour channel's serial multiply-divide lane.
  typedef struct packed {
    logic              load;
    logic [7:0]        from_lvl;
    logic signed [8:0] delta;
    logic [7:0]        step;
    logic [7:0]        steps;
  } lane_ctrl_t;

  function automatic seg_t builtin_seg(input logic [7:0] addr);
    seg_t s;
    s = '0;
    case (addr)
      8'd0:    s = '{8'd255, 8'd0,   8'd0,   8'd100};
      8'd1:    s = '{8'd0,   8'd255, 8'd0,   8'd100};
      8'd2:    s = '{8'd0,   8'd0,   8'd255, 8'd100};
      8'd3:    s = '{8'd255, 8'd0,   8'd0,   8'd50};
      8'd4:    s = '{8'd0,   8'd0,   8'd255, 8'd50};
      8'd5:    s = '{8'd0,   8'd255, 8'd0,   8'd75};
      8'd6:    s = '{8'd0,   8'd90,  8'd0,   8'd75};
      8'd7:    s = '{8'd150, 8'd14,  8'd235, 8'd40};
      8'd8:    s = '{8'd85,  8'd8,   8'd133, 8'd40};
      8'd9:    s = '{8'd85,  8'd64,  8'd64,  8'd40};
      8'd10:   s = '{8'd255, 8'd128, 8'd0,   8'd40};
      8'd11:   s = '{8'd255, 8'd0,   8'd0,   8'd15};
      8'd12:   s = '{8'd255, 8'd0,   8'd0,   8'd0};
      8'd13:   s = '{8'd0,   8'd0,   8'd0,   8'd15};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [5:0] builtin_first(input logic [2:0] id);
    logic [5:0] f;
    f = '0;
    case (id)
      3'd0:    f = 6'd0;
      3'd1:    f = 6'd3;
      3'd2:    f = 6'd5;
      3'd3:    f = 6'd7;
      3'd4:    f = 6'd11;
      default: f = 6'd0;
    endcase
    return f;
  endfunction

  function automatic logic [6:0] builtin_count(input logic [2:0] id);
    logic [6:0] c;
    c = '0;
    case (id)
      3'd0:    c = 7'd3;
      3'd1:    c = 7'd2;
      3'd2:    c = 7'd2;
      3'd3:    c = 7'd4;
      3'd4:    c = 7'd4;
      default: c = 7'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[src/rfps_seg_store.sv]
// ----------------------------------------------------------------------------
// Segment store
// Single-port-write, single-port-read memory of segments with registered read
// data. Per-entry valid bits make unwritten entries read as built-in contents.
// ----------------------------------------------------------------------------
`default_nettype none

module rfps_seg_store #(
  parameter int SEGMENTS = 64,
  parameter int AW       = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  rfps_pkg::seg_t      wr_data,
  input  logic [AW-1:0]       rd_addr,
  output rfps_pkg::seg_t      rd_data
);
  import rfps_pkg::*;

  seg_t                mem [SEGMENTS];
  logic [SEGMENTS-1:0] valid_r;
  seg_t                rd_data_r;
  logic                rd_valid_r;
  logic [AW-1:0]       rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_addr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : builtin_seg(8'(rd_addr_r));

endmodule

`default_nettype wire

[src/rfps_fade_lane.sv]
// ----------------------------------------------------------------------------
// Fade lane
// One colour channel: bit-serial shift-add multiply of |delta| by the step,
// bit-serial restoring divide by the step count, then sign and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module rfps_fade_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rfps_pkg::lane_ctrl_t ctrl,
  output logic [7:0]           level,
  output logic                 done
);
  import rfps_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lane_state_t;

  lane_state_t state_r;
  logic [3:0]  cnt_r;
  logic [15:0] dvd_r;
  logic [7:0]  rem_r;
  logic [7:0]  mcand_r;
  logic [7:0]  steps_r;
  logic [7:0]  from_r;
  logic        neg_r;
  logic [7:0]  level_r;
  logic        done_r;

  logic [8:0]  mag9;
  logic [8:0]  sum9;
  logic [8:0]  shifted;
  logic        q_bit;
  logic [8:0]  diff9;
  logic [16:0] up17;

  always_comb begin
    mag9    = ctrl.delta[8] ? (9'd0 - 9'(ctrl.delta)) : 9'(ctrl.delta);
    sum9    = 9'(dvd_r[15:8]) + (dvd_r[0] ? 9'(mcand_r) : 9'd0);
    shifted = {rem_r, dvd_r[15]};
    q_bit   = (shifted >= 9'(steps_r));
    diff9   = shifted - 9'(steps_r);
    up17    = 17'(from_r) + 17'(dvd_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (ctrl.load) begin
            dvd_r   <= {8'd0, mag9[7:0]};
            neg_r   <= ctrl.delta[8];
            mcand_r <= ctrl.step;
            steps_r <= ctrl.steps;
            from_r  <= ctrl.from_lvl;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= L_MUL;
          end
        end
        L_MUL: begin
          dvd_r <= {sum9, dvd_r[7:1]};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd7) begin
            cnt_r   <= '0;
            state_r <= L_DIV;
          end
        end
        L_DIV: begin
          rem_r <= q_bit ? diff9[7:0] : shifted[7:0];
          dvd_r <= {dvd_r[14:0], q_bit};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            cnt_r   <= '0;
            state_r <= L_FIN;
          end
        end
        L_FIN: begin
          if (steps_r == 8'd0) begin
            level_r <= from_r;
          end else if (neg_r) begin
            level_r <= (dvd_r > 16'(from_r)) ? 8'd0 : (from_r - dvd_r[7:0]);
          end else begin
            level_r <= (up17[16:8] != 9'd0) ? 8'hFF : up17[7:0];
          end
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign level = level_r;
  assign done  = done_r;

endmodule

`default_nettype wire

[src/rgb_fade_pattern_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// RGB fade pattern sequencer
// Plays colour fade patterns out of a segment store and a pattern table, one
// colour per tick command, with commands to start, stop and rewrite content.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Contents
//   -------   ----------------   ------------------------------------------
//   input     start, busy        command, pattern id, segment / entry data
//   result    out_strobe         red, green, blue levels and status
//
// An item is taken on a rising edge with start high and busy low. Every item
// gives exactly one result, shown for a single cycle under out_strobe.
// Start, stop, write and rejected commands finish in the cycle they are taken,
// so such items can follow one another on every clock.
// A tick while a pattern runs keeps busy high through T_CUR, T_NXT (on the
// first tick of a segment only), T_LOAD and T_RUN, where the bit-serial lanes
// multiply and then divide; the reads of the segment store are registered.
// Reset is synchronous and active low; it reloads the built-in segments and
// patterns (through per-entry valid bits in the store) and stops playback.
// The receiver cannot stall results, so none are ever held back.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_fade_pattern_sequencer_unit #(
  parameter int SEGMENTS = rfps_pkg::SEGMENTS_DEF,
  parameter int PATTERNS = rfps_pkg::PATTERNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_command,
  input  logic [2:0] in_pattern_id,
  input  logic [5:0] in_segment_addr,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic [7:0] in_step_count,
  input  logic [5:0] in_first_segment,
  input  logic [6:0] in_segment_total,
  output logic       out_strobe,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic       out_status
);
  import rfps_pkg::*;

  localparam int AW = $clog2(SEGMENTS);
  localparam int PW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;

  // The tick sequence: read the current segment, on a fresh segment also the
  // next one, then hand the three channels to the lanes and wait.
  typedef enum logic [2:0] {T_IDLE, T_CUR, T_NXT, T_LOAD, T_RUN} tick_state_t;

  tick_state_t       state_r;
  logic              running_r;
  logic [5:0]        act_start_r;
  logic [6:0]        act_count_r;
  logic [5:0]        seg_pos_r;
  logic [7:0]        step_pos_r;
  logic              fresh_r;
  logic [AW-1:0]     cur_addr_r;
  logic [7:0]        steps_r;
  logic [7:0]        from_r  [3];
  logic signed [8:0] delta_r [3];
  logic [5:0]        tab_first_r [PATTERNS];
  logic [6:0]        tab_count_r [PATTERNS];
  logic              out_strobe_r;
  logic              out_status_r;
  logic [7:0]        out_lvl_r [3];

  logic              accept;
  logic              pid_ok;
  logic [PW-1:0]     pid_idx;
  logic              pos_last;
  logic [AW-1:0]     addr_inc;
  logic [AW-1:0]     cur_addr_nxt;
  logic [5:0]        seg_pos_nxt;
  logic [7:0]        step_nxt;
  logic [AW-1:0]     rd_addr;
  seg_t              rd_data;
  logic [7:0]        rd_lvl [3];
  logic              seg_wr_en;
  seg_t              seg_wr_data;
  lane_ctrl_t        lane_ctrl [3];
  logic [7:0]        lane_level [3];
  logic [2:0]        lane_done;

  assign accept  = start && (state_r == T_IDLE);
  assign pid_ok  = (4'(in_pattern_id) < 4'(PATTERNS));
  assign pid_idx = in_pattern_id[PW-1:0];

  // Walk of the pattern's store addresses: first + position, kept as a
  // running address that wraps at the store size and returns to the first
  // segment after the last one.
  always_comb begin
    pos_last     = ((7'(seg_pos_r) + 7'd1) == act_count_r);
    addr_inc     = (9'(cur_addr_r) == 9'(SEGMENTS - 1)) ? '0 : (cur_addr_r + AW'(1));
    cur_addr_nxt = pos_last ? AW'(act_start_r) : addr_inc;
    seg_pos_nxt  = pos_last ? 6'd0 : (seg_pos_r + 6'd1);
    step_nxt     = step_pos_r + 8'd1;
  end

  assign rd_addr     = (state_r == T_CUR) ? cur_addr_nxt : cur_addr_r;
  assign seg_wr_en   = accept && (in_command == CMD_WR_SEG) &&
                       (9'(in_segment_addr) < 9'(SEGMENTS));
  assign seg_wr_data = '{in_red_in, in_green_in, in_blue_in, in_step_count};

  assign rd_lvl[0] = rd_data.red;
  assign rd_lvl[1] = rd_data.green;
  assign rd_lvl[2] = rd_data.blue;

  rfps_seg_store #(
    .SEGMENTS (SEGMENTS),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (seg_wr_en),
    .wr_addr (AW'(in_segment_addr)),
    .wr_data (seg_wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign lane_ctrl[k] = '{(state_r == T_LOAD), from_r[k], delta_r[k],
                            step_pos_r, steps_r};
    rfps_fade_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl[k]),
      .level (lane_level[k]),
      .done  (lane_done[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      running_r    <= 1'b0;
      act_start_r  <= '0;
      act_count_r  <= '0;
      seg_pos_r    <= '0;
      step_pos_r   <= '0;
      fresh_r      <= 1'b1;
      cur_addr_r   <= '0;
      steps_r      <= '0;
      out_strobe_r <= 1'b0;
      out_status_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        from_r[k]    <= '0;
        delta_r[k]   <= '0;
        out_lvl_r[k] <= '0;
      end
      for (int i = 0; i < PATTERNS; i++) begin
        tab_first_r[i] <= builtin_first(3'(i));
        tab_count_r[i] <= builtin_count(3'(i));
      end
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        T_IDLE: begin
          if (accept) begin
            // Non-tick commands answer black; the lanes only feed ticks.
            out_status_r <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              out_lvl_r[k] <= '0;
            end
            out_strobe_r <= 1'b1;
            case (in_command)
              CMD_TICK: begin
                if (running_r && (act_count_r != 7'd0)) begin
                  out_strobe_r <= 1'b0;
                  state_r      <= T_CUR;
                end
              end
              CMD_START: begin
                if (pid_ok) begin
                  running_r   <= 1'b1;
                  act_start_r <= tab_first_r[pid_idx];
                  act_count_r <= tab_count_r[pid_idx];
                  cur_addr_r  <= AW'(tab_first_r[pid_idx]);
                  seg_pos_r   <= '0;
                  step_pos_r  <= '0;
                  fresh_r     <= 1'b1;
                end else begin
                  out_status_r <= 1'b1;
                end
              end
              CMD_STOP: begin
                running_r <= 1'b0;
              end
              CMD_WR_SEG: begin
                out_status_r <= !(9'(in_segment_addr) < 9'(SEGMENTS));
              end
              CMD_WR_PAT: begin
                if (pid_ok && (9'(in_first_segment) < 9'(SEGMENTS)) &&
                    (in_segment_total != 7'd0) && (in_segment_total <= MAX_TOTAL)) begin
                  tab_first_r[pid_idx] <= in_first_segment;
                  tab_count_r[pid_idx] <= in_segment_total;
                end else begin
                  out_status_r <= 1'b1;
                end
              end
              default: out_status_r <= 1'b1;
            endcase
          end
        end
        T_CUR: begin
          // The step count is re-read on every tick.
          steps_r <= rd_data.steps;
          if (fresh_r) begin
            for (int k = 0; k < 3; k++) begin
              from_r[k] <= rd_lvl[k];
            end
            state_r <= T_NXT;
          end else begin
            state_r <= T_LOAD;
          end
        end
        T_NXT: begin
          for (int k = 0; k < 3; k++) begin
            delta_r[k] <= $signed(9'(rd_lvl[k]) - 9'(from_r[k]));
          end
          step_pos_r <= '0;
          fresh_r    <= 1'b0;
          state_r    <= T_LOAD;
        end
        T_LOAD: begin
          state_r <= T_RUN;
        end
        T_RUN: begin
          if (&lane_done) begin
            for (int k = 0; k < 3; k++) begin
              out_lvl_r[k] <= lane_level[k];
            end
            out_status_r <= 1'b0;
            out_strobe_r <= 1'b1;
            step_pos_r   <= step_nxt;
            if ((steps_r == 8'd0) || (steps_r == step_nxt)) begin
              fresh_r    <= 1'b1;
              seg_pos_r  <= seg_pos_nxt;
              cur_addr_r <= cur_addr_nxt;
            end
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign busy          = (state_r != T_IDLE);
  assign out_strobe    = out_strobe_r;
  assign out_status    = out_status_r;
  assign out_red_out   = out_lvl_r[0];
  assign out_green_out = out_lvl_r[1];
  assign out_blue_out  = out_lvl_r[2];

`ifndef NO_ASSERTIONS
  // A result only appears once the tick sequence has finished.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result shown while busy");

  // A rejected command never carries a colour.
  a_reject_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |->
      (out_red_out == 8'd0 && out_green_out == 8'd0 && out_blue_out == 8'd0))
    else $error("rejected command with colour");

  // The lanes finish together and only while the sequencer waits for them.
  a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_done) |-> ((&lane_done) && state_r == T_RUN))
    else $error("lane completion out of step");

  // The running store address stays inside the store.
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    9'(cur_addr_r) < 9'(SEGMENTS)) else $error("segment address out of range");
`endif

endmodule

`default_nettype wire
